/* hdl/mgr_pkg.sv */
// Shared types, constants and helpers for the 3x3 morphological gradient block.
`timescale 1ns / 1ps
`default_nettype none

package mgr_pkg;

   localparam int unsigned MAX_WIDTH_DEFAULT = 1024;
   localparam int unsigned PIX_W             = 8;
   localparam int unsigned CFG_W             = 11;
   localparam int unsigned IMAGE_WIDTH_RESET = 640;
   localparam int unsigned MIN_WIDTH         = 3;
   localparam int unsigned WIN_SPAN          = 3 - 1;
   localparam int unsigned WIN_COLS          = 3;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH = 3'd0;

   // running max / min of a group of pixels
   typedef struct packed {
      logic [PIX_W-1:0] hi;
      logic [PIX_W-1:0] lo;
   } mgr_stats_type;

   localparam mgr_stats_type STATS_NEUTRAL = '{hi: '0, lo: '1};

   function automatic mgr_stats_type stat_merge(input mgr_stats_type a,
                                                input mgr_stats_type b);
      mgr_stats_type r;
      r.hi = (a.hi > b.hi) ? a.hi : b.hi;
      r.lo = (a.lo < b.lo) ? a.lo : b.lo;
      return r;
   endfunction

   function automatic mgr_stats_type col_stats(input logic [PIX_W-1:0] p0,
                                               input logic [PIX_W-1:0] p1,
                                               input logic [PIX_W-1:0] p2);
      mgr_stats_type a;
      mgr_stats_type b;
      a = '{hi: p0, lo: p0};
      b = '{hi: p1, lo: p1};
      a = stat_merge(a, b);
      b = '{hi: p2, lo: p2};
      return stat_merge(a, b);
   endfunction

endpackage

`default_nettype wire

/* hdl/mgr_line_buf.sv */
// Two line stores: one-row and two-row delays of the pixel stream.
`timescale 1ns / 1ps
`default_nettype none

module mgr_line_buf #(
   parameter int unsigned MAX_WIDTH = mgr_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               rd_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]       addr,
   input  wire logic [mgr_pkg::PIX_W-1:0]          pixel,
   input  wire logic                               wb_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]       wb_addr,
   output logic      [mgr_pkg::PIX_W-1:0]          top_q,
   output logic      [mgr_pkg::PIX_W-1:0]          mid_q
);
   import mgr_pkg::*;

   logic [PIX_W-1:0] upper_line_ff  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_line_ff [MAX_WIDTH];
   logic [PIX_W-1:0] top_q_ff;
   logic [PIX_W-1:0] mid_q_ff;

   // middle store: read-first, then the new pixel goes in at the same column
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mid_q_ff <= middle_line_ff[addr];
         middle_line_ff[addr] <= pixel;
      end
   end

   // upper store takes the middle value in the next cycle, once it has been read out
   always_ff @(posedge clock) begin
      if (rd_en) begin
         top_q_ff <= upper_line_ff[addr];
      end
      if (wb_en) begin
         upper_line_ff[wb_addr] <= mid_q_ff;
      end
   end

   assign top_q = top_q_ff;
   assign mid_q = mid_q_ff;

endmodule

`default_nettype wire

/* hdl/mgr_win_cell.sv */
// One window column cell: holds its column's max/min and merges the window chain.
`timescale 1ns / 1ps
`default_nettype none

module mgr_win_cell (
   input  wire logic                  clock,
   input  wire logic                  shift_en,
   input  wire mgr_pkg::mgr_stats_type shift_in,
   input  wire mgr_pkg::mgr_stats_type partial_in,
   output mgr_pkg::mgr_stats_type     shift_out,
   output mgr_pkg::mgr_stats_type     partial_out
);
   import mgr_pkg::*;

   mgr_stats_type held_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         held_ff <= shift_in;
      end
   end

   assign shift_out   = held_ff;
   assign partial_out = stat_merge(held_ff, partial_in);

endmodule

`default_nettype wire

/* hdl/morphological_gradient_3x3.sv */
// Top level of the 3x3 morphological gradient (dilation minus erosion).
//
// Pixels enter on the req_ stream in raster order, one item per clock at
// most; req_tlast marks the final pixel of an image. Each pixel at flat
// index n >= 2*w+2 yields one item on the rsp_ stream: max minus min of the
// 3x3 window starting at index n-2*w-2 (rows wrap flatly). Earlier pixels
// of an image yield nothing. rsp_tlast follows the final pixel's result.
// image_width (csr_ offset 0) sets w, clamped to 3..MAX_WIDTH; a write also
// restarts the image. Write it only while the stream is idle.
// Throughput is one item per cycle when the output is not stalled, set by
// the line store read per pixel and the three-cell window chain. Items
// pass stage 1, the window cells and the output register in turn. Each
// stage holds its item until the next stage frees up, so the input keeps
// taking items while a result waits in the output register; req_tready
// falls only when all three stages are full and rsp_tready is low.
// Reset clears the stream position and sets image_width to 640; line store
// contents are not cleared and are never seen in a result.
`timescale 1ns / 1ps
`default_nettype none

module morphological_gradient_3x3 #(
   parameter int unsigned MAX_WIDTH = mgr_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,   // [7:0] pixel
   input  wire logic                               req_tlast,   // last_pixel
   // result stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [7:0]                         rsp_tdata,   // [7:0] gradient
   output logic                                    rsp_tlast,   // last_result
   // register port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [mgr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [mgr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [mgr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready
);
   import mgr_pkg::*;

   localparam int unsigned AW = $clog2(MAX_WIDTH);
   localparam int unsigned EW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned FW = $clog2(2 * MAX_WIDTH + 3);
   localparam int unsigned CW = (CFG_W > EW) ? CFG_W : EW;

   // ---------------- configuration ----------------
   logic [CFG_W-1:0] image_width_ff, image_width_in;
   logic             cfg_wr;
   logic [CW-1:0]    cfg_ext;
   logic [EW-1:0]    eff_w;
   logic [FW-1:0]    full_cnt;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == CSR_IMAGE_WIDTH);
   assign csr_prdata = (csr_paddr == CSR_IMAGE_WIDTH) ?
                       CSR_DATA_W'(image_width_ff) : '0;

   assign cfg_ext  = CW'(image_width_ff);
   assign eff_w    = (cfg_ext < CW'(MIN_WIDTH)) ? EW'(MIN_WIDTH) :
                     (cfg_ext > CW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(cfg_ext);
   assign full_cnt = FW'(eff_w) * FW'(WIN_SPAN) + FW'(WIN_SPAN);

   // ---------------- handshakes ----------------
   logic v1_ff, v1_in, v2_ff, v2_in, rsp_v_ff, rsp_v_in;
   logic en_out, en2, en1, acc;

   assign en_out     = !rsp_v_ff || rsp_tready;
   assign en2        = !v2_ff || en_out;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;
   assign acc        = req_tvalid && en1;

   // ---------------- stream position ----------------
   logic [AW-1:0] col_ff, col_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [EW-1:0] col_inc;
   logic          emit;

   assign col_inc = EW'(col_ff) + EW'(1);
   assign emit    = (fill_ff >= full_cnt);

   always_comb begin
      image_width_in = image_width_ff;
      col_in         = col_ff;
      fill_in        = fill_ff;
      if (cfg_wr) begin
         image_width_in = csr_pwdata[CFG_W-1:0];
         col_in         = '0;
         fill_in        = '0;
      end else if (acc) begin
         if (req_tlast) begin
            col_in  = '0;
            fill_in = '0;
         end else begin
            col_in = (col_inc >= eff_w) ? '0 : AW'(col_inc);
            if (!emit) begin
               fill_in = fill_ff + FW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= CFG_W'(IMAGE_WIDTH_RESET);
         col_ff         <= '0;
         fill_ff        <= '0;
      end else begin
         image_width_ff <= image_width_in;
         col_ff         <= col_in;
         fill_ff        <= fill_in;
      end
   end

   // ---------------- stage 1: line store read ----------------
   logic             emit1_ff, last1_ff;
   logic [PIX_W-1:0] px1_ff;
   logic [AW-1:0]    col1_ff;
   logic             wb_pend_ff;
   logic [PIX_W-1:0] top_q, mid_q;

   mgr_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (acc),
      .addr    (col_ff),
      .pixel   (req_tdata),
      .wb_en   (wb_pend_ff),
      .wb_addr (col1_ff),
      .top_q   (top_q),
      .mid_q   (mid_q)
   );

   always_ff @(posedge clock) begin
      if (acc) begin
         emit1_ff <= emit;
         last1_ff <= req_tlast;
         px1_ff   <= req_tdata;
         col1_ff  <= col_ff;
      end
   end

   // ---------------- stage 2: window cells ----------------
   logic          emit2_ff, last2_ff;
   logic          shift_en;
   mgr_stats_type head_in;
   mgr_stats_type cell_hold [WIN_COLS];
   mgr_stats_type cell_part [WIN_COLS];

   assign shift_en = en2 && v1_ff;
   assign head_in  = col_stats(top_q, mid_q, px1_ff);

   // newest column enters at the highest cell and moves down each item
   for (genvar g = 0; g < WIN_COLS; g++) begin : g_cell
      if (g == WIN_COLS - 1) begin : g_head
         mgr_win_cell u_cell (
            .clock       (clock),
            .shift_en    (shift_en),
            .shift_in    (head_in),
            .partial_in  (STATS_NEUTRAL),
            .shift_out   (cell_hold[g]),
            .partial_out (cell_part[g])
         );
      end else begin : g_body
         mgr_win_cell u_cell (
            .clock       (clock),
            .shift_en    (shift_en),
            .shift_in    (cell_hold[g+1]),
            .partial_in  (cell_part[g+1]),
            .shift_out   (cell_hold[g]),
            .partial_out (cell_part[g])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         emit2_ff <= emit1_ff;
         last2_ff <= last1_ff;
      end
   end

   // ---------------- output register ----------------
   logic [PIX_W-1:0] grad_ff;
   logic             rlast_ff;

   always_ff @(posedge clock) begin
      if (en_out) begin
         grad_ff  <= cell_part[0].hi - cell_part[0].lo;
         rlast_ff <= last2_ff;
      end
   end

   always_comb begin
      v1_in    = en1 ? acc : v1_ff;
      v2_in    = en2 ? v1_ff : v2_ff;
      rsp_v_in = en_out ? (v2_ff && emit2_ff) : rsp_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         rsp_v_ff   <= 1'b0;
         wb_pend_ff <= 1'b0;
      end else begin
         v1_ff      <= v1_in;
         v2_ff      <= v2_in;
         rsp_v_ff   <= rsp_v_in;
         wb_pend_ff <= acc;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = grad_ff;
   assign rsp_tlast  = rlast_ff;

`ifndef SYNTH
   a_result_issued : assert property (@(posedge clock) disable iff (reset)
      (v2_ff && emit2_ff && en_out) |=> rsp_tvalid)
      else $error("window result not issued");

   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && rsp_v_ff && !rsp_tready))
      else $error("input stalled with free stage");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= full_cnt)
      else $error("fill count beyond window size");

   a_col_bound : assert property (@(posedge clock) disable iff (reset)
      EW'(col_ff) < eff_w)
      else $error("column index beyond image width");

   a_wb_has_item : assert property (@(posedge clock) disable iff (reset)
      wb_pend_ff |-> v1_ff)
      else $error("upper store write without stage 1 item");
`endif

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the 3x3 morphological gradient block.
`timescale 1ns / 1ps

module tb;
   import mgr_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] grad;
      logic             lst;
   } grad_item_type;

   // Directed row: pixel, last flag, and an optional hand-computed gradient.
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             lst;
      logic             typed;
      logic [PIX_W-1:0] grad;
   } pixel_row_type;

   localparam int unsigned NUM_ROWS = 24;

   // Width 0 acts as 3, so the ninth pixel of an image gives the first result.
   localparam pixel_row_type PIXEL_ROWS [0:NUM_ROWS-1] = '{
      '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
      '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
      '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
      '{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h00, 1'b0, 1'b0, 8'h00},
      '{8'hFF, 1'b0, 1'b1, 8'hFF},
      '{8'h80, 1'b1, 1'b1, 8'hFF},
      // image ends before its window fills: no item, mark dropped
      '{8'h01, 1'b0, 1'b0, 8'h00}, '{8'h02, 1'b0, 1'b0, 8'h00},
      '{8'h03, 1'b1, 1'b0, 8'h00},
      // flat image ending in two differing pixels
      '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
      '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
      '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
      '{8'hFF, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
      '{8'hFF, 1'b0, 1'b1, 8'h00},
      '{8'h55, 1'b0, 1'b0, 8'h00},
      '{8'hAA, 1'b1, 1'b0, 8'h00}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] pixel
   logic                  req_tlast;   // last_pixel
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // [7:0] gradient
   logic                  rsp_tlast;   // last_result
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [PIX_W-1:0] upper_line [0:MAX_WIDTH_DEFAULT-1];
   logic [PIX_W-1:0] middle_line [0:MAX_WIDTH_DEFAULT-1];
   logic [PIX_W-1:0] window [0:2][0:2];
   int unsigned      pixels_taken;
   int unsigned      line_col;
   logic [CFG_W-1:0] width_reg;

   grad_item_type expected_grads [$];
   int unsigned   mismatch_count;
   int unsigned   send_idle_pct;
   int unsigned   stall_pct;

   morphological_gradient_3x3 dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w < MIN_WIDTH) w = MIN_WIDTH;
      if (w > MAX_WIDTH_DEFAULT) w = MAX_WIDTH_DEFAULT;
      return w;
   endfunction

   // Advance the predictor by one pixel; produced tells whether an item comes out.
   function automatic void predict_gradient(input logic [PIX_W-1:0] px, input logic lst,
                                            output bit produced,
                                            output logic [PIX_W-1:0] grad);
      int unsigned      w;
      int unsigned      col;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] hi;
      logic [PIX_W-1:0] lo;
      w = eff_width();
      col = (line_col >= w) ? 0 : line_col;
      top = upper_line[col];
      mid = middle_line[col];
      upper_line[col] = mid;
      middle_line[col] = px;
      for (int r = 0; r < 3; r++) begin
         window[r][0] = window[r][1];
         window[r][1] = window[r][2];
      end
      window[0][2] = top;
      window[1][2] = mid;
      window[2][2] = px;
      produced = (pixels_taken >= WIN_SPAN * w + WIN_SPAN);
      if (!produced) pixels_taken++;
      col++;
      line_col = (col >= w) ? 0 : col;
      if (lst) begin
         pixels_taken = 0;
         line_col = 0;
      end
      hi = '0;
      lo = '1;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (window[r][c] > hi) hi = window[r][c];
            if (window[r][c] < lo) lo = window[r][c];
         end
      end
      grad = hi - lo;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic check_width_readback();
      logic [CSR_DATA_W-1:0] got;
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = CSR_IMAGE_WIDTH;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if (got !== CSR_DATA_W'(width_reg))
         note_mismatch($sformatf("image_width read exp %0d got %0d", width_reg, got));
   endtask

   task automatic set_width(input logic [CFG_W-1:0] val);
      check_width_readback();
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_IMAGE_WIDTH;
      csr_pwdata = CSR_DATA_W'(val);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      width_reg = val;
      pixels_taken = 0;
      line_col = 0;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      check_width_readback();
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] px, input logic lst,
                             input logic typed, input logic [PIX_W-1:0] typed_grad);
      bit               produced;
      logic [PIX_W-1:0] grad;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = px;
      req_tlast = lst;
      do @(posedge clock); while (!req_tready);
      predict_gradient(px, lst, produced, grad);
      if (produced) expected_grads.push_back('{grad: typed ? typed_grad : grad, lst: lst});
   endtask

   // Let the pipeline empty out before touching the register.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_grads.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_idle_mode(input int unsigned mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 61; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 61; end
         default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
   endtask

   // result side
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      grad_item_type exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_grads.size() == 0) begin
            note_mismatch($sformatf("unexpected item grad %0d last %0b", rsp_tdata, rsp_tlast));
         end else begin
            exp_item = expected_grads.pop_front();
            if (rsp_tdata !== exp_item.grad || rsp_tlast !== exp_item.lst)
               note_mismatch($sformatf("grad exp %0d got %0d, last exp %0b got %0b",
                                       exp_item.grad, rsp_tdata, exp_item.lst, rsp_tlast));
         end
      end
   end

   initial begin
      int unsigned      phase;
      int unsigned      random_items;
      int unsigned      w;
      int unsigned      fill_len;
      int unsigned      len;
      int unsigned      n_images;
      bit               narrow;
      bit               open_tail;
      logic [PIX_W-1:0] base;
      logic [PIX_W-1:0] spread;
      logic [PIX_W-1:0] px;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatch_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      width_reg = CFG_W'(IMAGE_WIDTH_RESET);
      pixels_taken = 0;
      line_col = 0;
      for (int i = 0; i < MAX_WIDTH_DEFAULT; i++) begin
         upper_line[i] = '0;
         middle_line[i] = '0;
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            window[r][c] = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, width below the minimum
      set_width(CFG_W'(0));
      for (int i = 0; i < NUM_ROWS; i++)
         send_pixel(PIXEL_ROWS[i].pix, PIXEL_ROWS[i].lst, PIXEL_ROWS[i].typed,
                    PIXEL_ROWS[i].grad);
      drain();

      // widest setting, clamped to the line store depth: a short image that
      // ends while its window is still filling
      set_idle_mode(3);
      set_width('1);
      len = $urandom_range(8, 40);
      for (int i = 0; i < len; i++)
         send_pixel(8'($urandom_range(0, 255)), i == len - 1, 1'b0, '0);
      drain();

      // small widths, one to four images per setting
      phase = 0;
      random_items = 0;
      while (random_items < 700) begin
         set_idle_mode(phase);
         case ($urandom_range(0, 7))
            0: set_width(CFG_W'(MIN_WIDTH));
            1: set_width(CFG_W'($urandom_range(0, 2)));
            default: set_width(CFG_W'($urandom_range(4, 20)));
         endcase
         w = eff_width();
         fill_len = 2 * w + 2;
         n_images = $urandom_range(1, 4);
         for (int img = 0; img < n_images; img++) begin
            if ($urandom_range(0, 4) == 0) len = $urandom_range(1, fill_len);
            else len = fill_len + $urandom_range(1, 3 * w);
            open_tail = (img == n_images - 1) && ($urandom_range(0, 3) == 0);
            narrow = ($urandom_range(0, 2) == 0);
            base = 8'($urandom_range(0, 255));
            spread = 8'($urandom_range(0, 15));
            for (int i = 0; i < len; i++) begin
               if (narrow) px = base + 8'($urandom_range(0, spread));
               else px = 8'($urandom_range(0, 255));
               send_pixel(px, (i == len - 1) && !open_tail, 1'b0, '0);
               random_items++;
            end
         end
         drain();
         phase++;
      end

      if (mismatch_count == 0 && expected_grads.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* morphological_gradient_3x3.f */
hdl/mgr_pkg.sv
hdl/mgr_line_buf.sv
hdl/mgr_win_cell.sv
hdl/morphological_gradient_3x3.sv
verif/tb.sv
